FILE: hdl/frsc_pkg.sv
package frsc_pkg;

    localparam int unsigned HDR_BYTES = 4;
    localparam int unsigned POS_W     = 11;

    localparam logic [7:0]       DELIM   = 8'h7E;
    localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

    // Verdict codes; the per-frame status uses the first four
    localparam logic [2:0] VERD_ACCEPT = 3'd0;
    localparam logic [2:0] VERD_DROP   = 3'd1;
    localparam logic [2:0] VERD_AHEAD  = 3'd2;
    localparam logic [2:0] VERD_OLD    = 3'd3;
    localparam logic [2:0] VERD_BADSUM = 3'd4;

    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NACK = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // One queue entry: everything a single received byte causes
    typedef struct packed {
        logic       has_payload;
        logic       has_verdict;
        logic [7:0] payload_byte;
        logic [2:0] verdict;
        logic [1:0] reply_kind;
        logic [3:0] msg_type;
        logic [6:0] msg_size;
        logic [4:0] msg_seq;
    } t_entry;

endpackage

FILE: hdl/frame_receiver_seq_check_top.sv
// Frame receiver with sequence check and XOR checksum.
// Input channel: one received byte per beat on i_rx_byte, with i_frame_end on
// the last byte of a frame and i_expecting_reply sampled on the first byte.
// A beat is taken when i_in_valid is high and o_in_stall is low.
// Output channel: o_item_kind 0 carries a payload byte with the header fields,
// o_item_kind 1 carries the frame verdict, reply and header fields, with
// o_is_last set. A beat is taken when o_out_valid is high and i_out_stall low.
// An accepted byte's result goes through the queue and then the output register.
// Throughput: one byte per cycle while o_in_stall is low. A frame's last payload
// byte, when it is also the end of the frame, gives two output beats; the single
// output register is the limit.
// The queue of QUEUE_DEPTH entries between the byte classifier and the output
// stage absorbs that and output stalls; o_in_stall rises only when it is full.
// Reset clears all per-frame state, sets the expected sequence to zero and
// empties the queue and the output register.
module frame_receiver_seq_check_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_end,
    input  logic       i_expecting_reply,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_item_kind,
    output logic [7:0] o_payload_byte,
    output logic [2:0] o_verdict,
    output logic [1:0] o_reply_kind,
    output logic [3:0] o_msg_type,
    output logic [6:0] o_msg_size,
    output logic [4:0] o_msg_seq,
    output logic       o_is_last
);
    import frsc_pkg::*;

    logic   accept;
    logic   push;
    t_entry push_entry;
    logic   pop;
    t_entry head;
    logic   q_empty;
    logic   q_full;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    frsc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_rx_byte         (i_rx_byte),
        .i_frame_end       (i_frame_end),
        .i_expecting_reply (i_expecting_reply),
        .o_push            (push),
        .o_push_entry      (push_entry)
    );

    frsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_empty      (q_empty),
        .o_full       (q_full)
    );

    frsc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_item_kind    (o_item_kind),
        .o_payload_byte (o_payload_byte),
        .o_verdict      (o_verdict),
        .o_reply_kind   (o_reply_kind),
        .o_msg_type     (o_msg_type),
        .o_msg_size     (o_msg_size),
        .o_msg_seq      (o_msg_seq),
        .o_is_last      (o_is_last)
    );

endmodule

FILE: hdl/frsc_front.sv
module frsc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_rx_byte,
    input  logic            i_frame_end,
    input  logic            i_expecting_reply,
    output logic            o_push,
    output frsc_pkg::t_entry o_push_entry
);
    import frsc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_hdr, n_hdr;
    logic [7:0]       r_xor, n_xor;
    logic [4:0]       r_exp_seq, n_exp_seq;
    logic [2:0]       r_status, n_status;
    logic             r_latch, n_latch;

    logic [31:0]      hdr_cur;
    logic [7:0]       xor_cur;
    logic [2:0]       status_cur;
    logic             latch_cur;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] size_end;
    logic [4:0]       seq_dist;
    logic [2:0]       verdict;
    logic [1:0]       reply;
    logic             pl_out;

    // Size field sits in the same place once the header is in
    assign size_end = POS_W'({4'b0, hdr_cur[14:8]}) + POS_W'(HDR_BYTES);
    assign seq_dist = hdr_cur[19:15] - r_exp_seq;

    always_comb begin
        hdr_cur    = r_hdr;
        xor_cur    = r_xor;
        status_cur = r_status;
        latch_cur  = r_latch;
        pl_out     = 1'b0;
        verdict    = VERD_ACCEPT;
        reply      = REPLY_NONE;
        pos_inc    = (r_pos < POS_MAX) ? r_pos + POS_W'(1) : r_pos;

        if (r_pos == '0) begin
            latch_cur = i_expecting_reply;
        end

        if (r_pos < POS_W'(HDR_BYTES)) begin
            unique case (r_pos[1:0])
                2'd0: hdr_cur[7:0]   = i_rx_byte;
                2'd1: hdr_cur[15:8]  = i_rx_byte;
                2'd2: hdr_cur[23:16] = i_rx_byte;
                2'd3: hdr_cur[31:24] = i_rx_byte;
                default: hdr_cur = r_hdr;
            endcase
            if (r_pos[1:0] == 2'd3) begin
                if (hdr_cur[7:0] != DELIM) begin
                    status_cur = VERD_DROP;
                end else if (seq_dist == '0) begin
                    status_cur = VERD_ACCEPT;
                end else if (!seq_dist[4]) begin
                    status_cur = VERD_AHEAD;
                end else begin
                    status_cur = VERD_OLD;
                end
                xor_cur = DELIM ^ {1'b0, hdr_cur[14:8]} ^ {3'b0, hdr_cur[19:15]}
                        ^ {4'b0, hdr_cur[23:20]};
            end
        end else if (r_status == VERD_ACCEPT && r_pos < size_end) begin
            xor_cur = r_xor ^ i_rx_byte;
            pl_out  = 1'b1;
        end

        if (pos_inc < POS_W'(HDR_BYTES)) begin
            verdict = VERD_DROP;
        end else if (status_cur != VERD_ACCEPT) begin
            verdict = status_cur;
        end else if (pos_inc < size_end || xor_cur != hdr_cur[31:24]) begin
            verdict = VERD_BADSUM;
        end else begin
            verdict = VERD_ACCEPT;
        end

        unique case (verdict)
            VERD_ACCEPT: reply = latch_cur ? REPLY_NONE : REPLY_ACK;
            VERD_AHEAD:  reply = latch_cur ? REPLY_NONE : REPLY_NACK;
            VERD_OLD:    reply = REPLY_ACK;
            VERD_BADSUM: reply = latch_cur ? REPLY_NONE : REPLY_NACK;
            default:     reply = REPLY_NONE;
        endcase
    end

    always_comb begin
        o_push_entry              = '0;
        o_push_entry.has_payload  = pl_out;
        o_push_entry.has_verdict  = i_frame_end;
        o_push_entry.payload_byte = i_rx_byte;
        o_push_entry.verdict      = i_frame_end ? verdict : VERD_ACCEPT;
        o_push_entry.reply_kind   = i_frame_end ? reply : REPLY_NONE;
        // A frame too short for a header reports empty fields
        if (!(i_frame_end && pos_inc < POS_W'(HDR_BYTES))) begin
            o_push_entry.msg_type = hdr_cur[23:20];
            o_push_entry.msg_size = hdr_cur[14:8];
            o_push_entry.msg_seq  = hdr_cur[19:15];
        end
    end

    assign o_push = i_accept && (pl_out || i_frame_end);

    always_comb begin
        n_pos     = r_pos;
        n_hdr     = r_hdr;
        n_xor     = r_xor;
        n_status  = r_status;
        n_latch   = r_latch;
        n_exp_seq = r_exp_seq;
        if (i_accept) begin
            if (i_frame_end) begin
                // clear per-frame state; the expected sequence advances only on an accepted frame
                n_pos    = '0;
                n_hdr    = '0;
                n_xor    = '0;
                n_status = VERD_ACCEPT;
                n_latch  = 1'b0;
                if (verdict == VERD_ACCEPT) begin
                    n_exp_seq = r_exp_seq + 5'd1;
                end
            end else begin
                n_pos    = pos_inc;
                n_hdr    = hdr_cur;
                n_xor    = xor_cur;
                n_status = status_cur;
                n_latch  = latch_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hdr     <= '0;
            r_xor     <= '0;
            r_status  <= VERD_ACCEPT;
            r_latch   <= 1'b0;
            r_exp_seq <= '0;
        end else begin
            r_pos     <= n_pos;
            r_hdr     <= n_hdr;
            r_xor     <= n_xor;
            r_status  <= n_status;
            r_latch   <= n_latch;
            r_exp_seq <= n_exp_seq;
        end
    end

    a_seq_moves_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_exp_seq)) |->
            $past(o_push && o_push_entry.has_verdict && o_push_entry.verdict == VERD_ACCEPT))
        else $error("expected sequence moved without an accepted frame");

    a_payload_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_push_entry.has_payload) |-> (r_pos >= POS_W'(HDR_BYTES)
            && r_status == VERD_ACCEPT))
        else $error("payload beat issued inside header or for a rejected frame");

    a_status_clean_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == '0) |-> (r_status == VERD_ACCEPT && r_hdr == '0 && r_xor == '0))
        else $error("per-frame state not cleared at frame start");

endmodule

FILE: hdl/frsc_queue.sv
module frsc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  frsc_pkg::t_entry i_push_entry,
    input  logic             i_pop,
    output frsc_pkg::t_entry o_head,
    output logic             o_empty,
    output logic             o_full
);
    import frsc_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_entry           r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("entry pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("entry popped from an empty queue");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

FILE: hdl/frsc_back.sv
module frsc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  frsc_pkg::t_entry i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_item_kind,
    output logic [7:0]       o_payload_byte,
    output logic [2:0]       o_verdict,
    output logic [1:0]       o_reply_kind,
    output logic [3:0]       o_msg_type,
    output logic [6:0]       o_msg_size,
    output logic [4:0]       o_msg_seq,
    output logic             o_is_last
);
    import frsc_pkg::*;

    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_payload;
    logic [2:0] r_verdict;
    logic [1:0] r_reply;
    logic [3:0] r_type;
    logic [6:0] r_size;
    logic [4:0] r_seq;
    logic       r_pend_valid;
    logic [2:0] r_pend_verdict;
    logic [1:0] r_pend_reply;
    logic       out_free;

    assign out_free = !r_valid || !i_out_stall;
    // A pending verdict goes out before the next entry is taken
    assign o_pop    = out_free && !r_pend_valid && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_valid      <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (!i_empty) begin
                r_valid      <= 1'b1;
                r_pend_valid <= i_head.has_payload && i_head.has_verdict;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                // header fields stay from the payload beat just taken
                r_kind    <= KIND_VERDICT;
                r_payload <= '0;
                r_verdict <= r_pend_verdict;
                r_reply   <= r_pend_reply;
            end else if (!i_empty) begin
                r_type <= i_head.msg_type;
                r_size <= i_head.msg_size;
                r_seq  <= i_head.msg_seq;
                if (i_head.has_payload) begin
                    r_kind    <= KIND_PAYLOAD;
                    r_payload <= i_head.payload_byte;
                    r_verdict <= VERD_ACCEPT;
                    r_reply   <= REPLY_NONE;
                end else begin
                    r_kind    <= KIND_VERDICT;
                    r_payload <= '0;
                    r_verdict <= i_head.verdict;
                    r_reply   <= i_head.reply_kind;
                end
                r_pend_verdict <= i_head.verdict;
                r_pend_reply   <= i_head.reply_kind;
            end
        end
    end

    assign o_out_valid    = r_valid;
    assign o_item_kind    = r_kind;
    assign o_payload_byte = r_payload;
    assign o_verdict      = r_verdict;
    assign o_reply_kind   = r_reply;
    assign o_msg_type     = r_type;
    assign o_msg_size     = r_size;
    assign o_msg_seq      = r_seq;
    assign o_is_last      = (r_kind == KIND_VERDICT);

    a_pend_behind_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_valid && r_kind == KIND_PAYLOAD))
        else $error("pending verdict without a payload beat in front");

    a_verdict_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_stall && r_pend_valid) |=> (r_valid && r_kind == KIND_VERDICT))
        else $error("verdict did not follow its payload beat");

    a_no_pop_while_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> !o_pop)
        else $error("entry taken while a verdict is pending");

endmodule

FILE: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import frsc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_BYTES = 2000;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload;
        logic [2:0] verdict;
        logic [1:0] reply;
        logic [3:0] mtype;
        logic [6:0] msize;
        logic [4:0] mseq;
        logic       last;
    } t_out_item;

    // Predicts the payload and verdict beats of the receiver and checks them in order
    class frame_verdict_model;
        logic [10:0] byte_pos = '0;
        logic [31:0] hdr      = '0;
        logic [7:0]  run_xor  = '0;
        logic [4:0]  exp_seq  = '0;
        logic [2:0]  status   = VERD_ACCEPT;
        logic        latch    = 1'b0;
        t_out_item   expected_items[$];
        int          errors   = 0;

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return expected_items.size();
        endfunction

        function void take_byte(logic [7:0] b, logic fe, logic er);
            logic [10:0] pos;
            logic [6:0]  size;
            logic [4:0]  seq;
            logic [3:0]  mtype;
            logic [4:0]  seq_dist;
            logic [31:0] hw;
            logic [2:0]  v;
            logic [1:0]  rk;
            t_out_item   it;
            pos  = byte_pos;
            size = hdr[14:8];
            if (pos == 0)
                latch = er;
            if (pos < HDR_BYTES) begin
                hdr = hdr | ({24'd0, b} << (8 * pos));
                if (pos == HDR_BYTES - 1) begin
                    seq   = hdr[19:15];
                    mtype = hdr[23:20];
                    size  = hdr[14:8];
                    if (hdr[7:0] != DELIM) begin
                        status = VERD_DROP;
                    end else begin
                        seq_dist = seq - exp_seq;
                        if (seq_dist == 0)
                            status = VERD_ACCEPT;
                        else if (seq_dist < 16)
                            status = VERD_AHEAD;
                        else
                            status = VERD_OLD;
                    end
                    run_xor = DELIM ^ {1'b0, size} ^ {3'b0, seq} ^ {4'b0, mtype};
                end
            end else if (status == VERD_ACCEPT && (pos - HDR_BYTES) < size) begin
                run_xor ^= b;
                it = '{KIND_PAYLOAD, b, VERD_ACCEPT, REPLY_NONE,
                       hdr[23:20], hdr[14:8], hdr[19:15], 1'b0};
                expected_items.push_back(it);
            end

            // position saturates on very long frames
            if (pos < POS_MAX)
                pos++;
            byte_pos = pos;

            if (fe) begin
                if (pos < HDR_BYTES) begin
                    v  = VERD_DROP;
                    hw = '0;
                end else begin
                    hw = hdr;
                    if (status != VERD_ACCEPT)
                        v = status;
                    else if ((pos - HDR_BYTES) < hw[14:8] || run_xor != hw[31:24])
                        v = VERD_BADSUM;
                    else
                        v = VERD_ACCEPT;
                end
                case (v)
                    VERD_ACCEPT: rk = latch ? REPLY_NONE : REPLY_ACK;
                    VERD_AHEAD:  rk = latch ? REPLY_NONE : REPLY_NACK;
                    VERD_OLD:    rk = REPLY_ACK;
                    VERD_BADSUM: rk = latch ? REPLY_NONE : REPLY_NACK;
                    default:     rk = REPLY_NONE;
                endcase
                if (v == VERD_ACCEPT)
                    exp_seq++;
                it = '{KIND_VERDICT, 8'd0, v, rk, hw[23:20], hw[14:8], hw[19:15], 1'b1};
                expected_items.push_back(it);
                byte_pos = '0;
                hdr      = '0;
                run_xor  = '0;
                status   = VERD_ACCEPT;
                latch    = 1'b0;
            end
        endfunction

        task cmp_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_item(t_out_item got);
            t_out_item want;
            if (expected_items.size() == 0) begin
                report_mismatch("output beat with nothing expected");
                return;
            end
            want = expected_items.pop_front();
            cmp_field("item_kind", got.kind, want.kind);
            cmp_field("payload_byte", got.payload, want.payload);
            cmp_field("verdict", got.verdict, want.verdict);
            cmp_field("reply_kind", got.reply, want.reply);
            cmp_field("msg_type", got.mtype, want.mtype);
            cmp_field("msg_size", got.msize, want.msize);
            cmp_field("msg_seq", got.mseq, want.mseq);
            cmp_field("is_last", got.last, want.last);
        endtask
    endclass

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_in_valid        = 1'b0;
    logic [7:0] i_rx_byte         = '0;
    logic       i_frame_end       = 1'b0;
    logic       i_expecting_reply = 1'b0;
    logic       i_out_stall       = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_item_kind;
    logic [7:0] o_payload_byte;
    logic [2:0] o_verdict;
    logic [1:0] o_reply_kind;
    logic [3:0] o_msg_type;
    logic [6:0] o_msg_size;
    logic [4:0] o_msg_seq;
    logic       o_is_last;

    frame_verdict_model sb;
    int   bytes_sent  = 0;
    int   cycle_count = 0;
    logic no_idle     = 1'b0;
    logic hold_req    = 1'b0;

    frame_receiver_seq_check_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .i_frame_end       (i_frame_end),
        .i_expecting_reply (i_expecting_reply),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_item_kind       (o_item_kind),
        .o_payload_byte    (o_payload_byte),
        .o_verdict         (o_verdict),
        .o_reply_kind      (o_reply_kind),
        .o_msg_type        (o_msg_type),
        .o_msg_size        (o_msg_size),
        .o_msg_seq         (o_msg_seq),
        .o_is_last         (o_is_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[frame_receiver_seq_check_top] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_out_item got;
        got = '{o_item_kind, o_payload_byte, o_verdict, o_reply_kind,
                o_msg_type, o_msg_size, o_msg_seq, o_is_last};
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_item(got);
    end

    // Receiver: random stalls, plus one long hold-off to fill the block
    initial begin
        int  hold_left;
        logic hold_served;
        hold_left   = 0;
        hold_served = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_served) begin
                hold_left   = 300;
                hold_served = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !no_idle && ($urandom_range(99) < 20);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fe, input logic er);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 20) ? $urandom_range(1, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_rx_byte         <= b;
        i_frame_end       <= fe;
        i_expecting_reply <= er;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_byte(b, fe, er);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] delim, input logic [6:0] size,
                              input logic [4:0] seq, input logic [3:0] mtype,
                              input logic bad_sum, input int length, input logic er);
        logic [7:0] body [128];
        logic [7:0] sum;
        logic [7:0] b;
        int i;
        sum = DELIM ^ {1'b0, size} ^ {3'b0, seq} ^ {4'b0, mtype};
        for (i = 0; i < size; i++) begin
            body[i] = 8'($urandom);
            sum ^= body[i];
        end
        if (bad_sum)
            sum ^= 8'($urandom_range(1, 255));
        for (i = 0; i < length; i++) begin
            case (i)
                0: b = delim;
                1: b = {seq[0], size};
                2: b = {mtype, seq[4:1]};
                3: b = sum;
                default: b = (i - 4 < size) ? body[i - 4] : 8'($urandom);
            endcase
            send_byte(b, i == length - 1, (i == 0) ? er : 1'($urandom_range(1)));
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] delim;
        logic [6:0] size;
        logic [4:0] seq;
        int r;
        int length;
        delim = ($urandom_range(99) < 4) ? 8'($urandom) : DELIM;
        r = $urandom_range(99);
        if (r < 70)
            seq = sb.exp_seq;
        else if (r < 85)
            seq = sb.exp_seq + 5'($urandom_range(1, 15));
        else
            seq = sb.exp_seq - 5'($urandom_range(1, 16));
        r = $urandom_range(99);
        if (r < 85)
            size = 7'($urandom_range(0, 8));
        else if (r < 95)
            size = 7'($urandom_range(9, 40));
        else
            size = 7'($urandom_range(100, 127));
        r = $urandom_range(99);
        if (r < 80)
            length = 4 + size;
        else if (r < 90)
            length = $urandom_range(1, 3 + size);
        else
            length = 4 + size + $urandom_range(1, 4);
        send_frame(delim, size, seq, 4'($urandom), $urandom_range(99) < 10, length,
                   1'($urandom_range(1)));
    endtask

    initial begin
        int start;
        sb = new;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // runt, bad delimiter, in order with excess bytes under a reply latch,
        // old duplicate, ahead, short payload, bad checksum
        send_frame(8'hFF, 7'd127, 5'd31, 4'd15, 1'b0, 2, 1'b1);
        send_frame(8'h00, 7'd0, 5'd0, 4'd0, 1'b0, 4, 1'b0);
        send_frame(DELIM, 7'd1, 5'd0, 4'd15, 1'b0, 6, 1'b1);
        send_frame(DELIM, 7'd0, 5'd0, 4'd0, 1'b0, 4, 1'b0);
        send_frame(DELIM, 7'd0, 5'd16, 4'd3, 1'b0, 4, 1'b0);
        send_frame(DELIM, 7'd2, 5'd1, 4'd7, 1'b0, 5, 1'b0);
        send_frame(DELIM, 7'd0, 5'd1, 4'd8, 1'b1, 4, 1'b1);

        start = bytes_sent;
        while (bytes_sent < start + RANDOM_BYTES) begin
            if (bytes_sent > start + 300)
                hold_req = 1'b1;
            no_idle = (bytes_sent > start + 900) && (bytes_sent < start + 1300);
            send_random_frame();
        end
        no_idle = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[frame_receiver_seq_check_top] OK");
        else
            $display("[frame_receiver_seq_check_top] ERROR");
        $finish;
    end
endmodule

FILE: files.f
hdl/frsc_pkg.sv
hdl/frsc_front.sv
hdl/frsc_queue.sv
hdl/frsc_back.sv
hdl/frame_receiver_seq_check_top.sv
test/testbench.sv
